/* hw/rtl/pwbs_pkg.sv */
// Shared types, constants and codes of the position window bound search block.
`default_nettype none

package pwbs_pkg;

    localparam int IDX_W       = 12;
    localparam int LEN_W       = 13;
    localparam int POS_W       = 32;
    localparam int MAX_ENTRIES = 2 ** IDX_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LOCI    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_SEL    = 2'd2;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef enum logic {
        DIR_RIGHT = 1'b0,
        DIR_LEFT  = 1'b1
    } t_dir;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_NEXT,
        RD_INNER
    } t_rd_sel;

    typedef enum logic [1:0] {
        BND_CUR,
        BND_INNER,
        BND_NEAR
    } t_bnd_sel;

    typedef struct packed {
        t_func             func;
        logic [IDX_W-1:0]  index;
        logic [POS_W-1:0]  position;
    } t_in_word;

    typedef struct packed {
        logic              window_found;
        logic [IDX_W-1:0]  left_count;
        logic [IDX_W-1:0]  right_count;
        logic [LEN_W-1:0]  window_length;
        logic [LEN_W-1:0]  max_length;
    } t_out_word;

    typedef struct packed {
        logic      cap_idx;
        logic      cur_load;
        logic      cur_step;
        logic      rd_en;
        t_rd_sel   rd_sel;
        t_dir      dir;
        logic      cap_ref;
        logic      cap_outer;
        logic      bnd_we;
        t_bnd_sel  bnd_sel;
        logic      clr_longest;
        logic      mem_we;
        logic      out_load;
        logic      out_ok;
    } t_cmd;

    typedef struct packed {
        logic pre_bad;
        logic walk_lt;
        logic walk_eq;
        logic at_end;
        logic out_free;
        logic near_sel;
    } t_stat;

endpackage

`default_nettype wire

/* hw/rtl/pwbs_in_if.sv */
// Input channel: valid/ready handshake carrying one load or query word.
`default_nettype none

interface pwbs_in_if;
    import pwbs_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pwbs_out_if.sv */
// Result channel: valid/ready handshake carrying one window result word.
`default_nettype none

interface pwbs_out_if;
    import pwbs_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pwbs_ctrl.sv */
// Sequencer for the position window bound search: walks each side, then issues the result.
`default_nettype none

module pwbs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  pwbs_pkg::t_func     i_in_func,
    input  pwbs_pkg::t_stat     i_stat,
    output logic                o_in_ready,
    output pwbs_pkg::t_cmd      o_cmd
);
    import pwbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_REF,
        S_WALK,
        S_NEAR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_dir   r_dir,   n_dir;
    logic   r_found, n_found;

    always_comb begin
        logic side_end;
        side_end  = 1'b0;
        n_state   = r_state;
        n_dir     = r_dir;
        n_found   = r_found;
        o_cmd     = '0;
        o_cmd.dir = r_dir;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_func == FUNC_LOAD) begin
                        o_cmd.mem_we      = 1'b1;
                        o_cmd.clr_longest = 1'b1;
                    end else begin
                        o_cmd.cap_idx = 1'b1;
                        n_dir         = DIR_RIGHT;
                        n_state       = S_START;
                    end
                end
            end
            S_START: begin
                if (i_stat.pre_bad) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.cur_load = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = RD_IDX;
                    n_state        = S_REF;
                end
            end
            S_REF: begin
                // read data still holds the centre entry for the first walk step
                o_cmd.cap_ref = 1'b1;
                n_state       = S_WALK;
            end
            S_WALK: begin
                if (i_stat.walk_lt && !i_stat.at_end) begin
                    o_cmd.cur_step = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = RD_NEXT;
                end else if (i_stat.walk_eq) begin
                    o_cmd.bnd_we  = 1'b1;
                    o_cmd.bnd_sel = BND_CUR;
                    side_end      = 1'b1;
                end else if (i_stat.walk_lt) begin
                    // border reached short of reach: drop the window
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else if (i_stat.near_sel) begin
                    o_cmd.cap_outer = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_sel    = RD_INNER;
                    n_state         = S_NEAR;
                end else begin
                    o_cmd.bnd_we  = 1'b1;
                    o_cmd.bnd_sel = BND_INNER;
                    side_end      = 1'b1;
                end
            end
            S_NEAR: begin
                o_cmd.bnd_we  = 1'b1;
                o_cmd.bnd_sel = BND_NEAR;
                side_end      = 1'b1;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_ok   = r_found;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (side_end) begin
            if (r_dir == DIR_RIGHT) begin
                // restart from the centre for the left walk
                n_dir          = DIR_LEFT;
                o_cmd.cur_load = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RD_IDX;
                n_state        = S_WALK;
            end else begin
                n_found = 1'b1;
                n_state = S_DONE;
            end
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dir   <= DIR_RIGHT;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dir   <= n_dir;
            r_found <= n_found;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pwbs_dpath.sv */
// Datapath: position table, walk cursor, distance compares, bounds and result register.
`default_nettype none

module pwbs_dpath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [pwbs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [pwbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  pwbs_pkg::t_in_word               i_in_word,
    input  pwbs_pkg::t_cmd                   i_cmd,
    input  wire                              i_out_ready,
    output pwbs_pkg::t_stat                  o_stat,
    output logic                             o_out_valid,
    output pwbs_pkg::t_out_word              o_out_word
);
    import pwbs_pkg::*;

    localparam int DIST_W    = POS_W + 1;
    localparam int SGN_W     = POS_W + 3;
    localparam int MIN_LOCI  = 3;

    // configuration
    logic [POS_W-1:0]  r_window_size;
    logic [LEN_W-1:0]  r_num_loci;
    logic              r_near_sel;

    // table and working registers
    logic [POS_W-1:0]  r_table [MAX_ENTRIES];
    logic [POS_W-1:0]  r_rd_data;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_cur;
    logic [POS_W-1:0]  r_ref;
    logic [POS_W-1:0]  r_outer;
    logic [IDX_W-1:0]  r_start;
    logic [IDX_W-1:0]  r_stop;
    logic [LEN_W-1:0]  r_longest;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic [LEN_W-1:0]  loci_cnt;
    logic [LEN_W-1:0]  loci_last;
    logic [DIST_W-1:0] half;
    logic [POS_W-1:0]  diff;
    logic [DIST_W-1:0] walk_d;
    logic [IDX_W-1:0]  cur_next;
    logic [IDX_W-1:0]  cur_inner;
    logic [IDX_W-1:0]  rd_addr;
    logic signed [SGN_W-1:0] target;
    logic signed [SGN_W-1:0] d_in_s;
    logic signed [SGN_W-1:0] d_out_s;
    logic [SGN_W-1:0]  d_in_abs;
    logic [SGN_W-1:0]  d_out_abs;
    logic [IDX_W-1:0]  bound;
    logic              win_ok;
    logic [LEN_W-1:0]  win_len;
    logic [LEN_W-1:0]  longest_upd;
    logic              is_right;

    assign is_right  = (i_cmd.dir == DIR_RIGHT);
    assign loci_cnt  = (r_num_loci > LEN_W'(MAX_ENTRIES)) ? LEN_W'(MAX_ENTRIES) : r_num_loci;
    assign loci_last = loci_cnt - LEN_W'(1);
    assign half      = {2'b00, r_window_size[POS_W-1:1]};

    // walk distance wraps modulo the position width, plus one
    assign diff      = is_right ? (r_rd_data - r_ref) : (r_ref - r_rd_data);
    assign walk_d    = {1'b0, diff} + DIST_W'(1);
    assign cur_next  = is_right ? (r_cur + IDX_W'(1)) : (r_cur - IDX_W'(1));
    assign cur_inner = is_right ? (r_cur - IDX_W'(1)) : (r_cur + IDX_W'(1));

    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX:   rd_addr = r_idx;
            RD_NEXT:  rd_addr = cur_next;
            RD_INNER: rd_addr = cur_inner;
            default:  rd_addr = r_idx;
        endcase
    end

    // nearness to target on true values: read data is the inner entry here
    assign target  = is_right
                   ? ($signed({3'b000, r_ref}) + $signed({2'b00, half}))
                   : ($signed({3'b000, r_ref}) - $signed({2'b00, half}));
    assign d_in_s  = $signed({3'b000, r_rd_data}) - target;
    assign d_out_s = $signed({3'b000, r_outer}) - target;
    assign d_in_abs  = d_in_s[SGN_W-1]  ? SGN_W'(-d_in_s)  : SGN_W'(d_in_s);
    assign d_out_abs = d_out_s[SGN_W-1] ? SGN_W'(-d_out_s) : SGN_W'(d_out_s);

    always_comb begin
        case (i_cmd.bnd_sel)
            BND_CUR:   bound = r_cur;
            BND_INNER: bound = cur_inner;
            BND_NEAR:  bound = (d_out_abs > d_in_abs) ? cur_inner : r_cur;
            default:   bound = r_cur;
        endcase
    end

    assign win_ok      = i_cmd.out_ok && !(r_start > r_idx) && !(r_stop < r_idx);
    assign win_len     = {1'b0, r_stop} - {1'b0, r_start} + LEN_W'(1);
    assign longest_upd = (win_ok && (win_len > r_longest)) ? win_len : r_longest;

    always_comb begin
        o_stat          = '0;
        o_stat.pre_bad  = (loci_cnt < LEN_W'(MIN_LOCI)) || (r_idx == '0)
                        || ({1'b0, r_idx} >= loci_last);
        o_stat.walk_lt  = (walk_d < half);
        o_stat.walk_eq  = (walk_d == half);
        o_stat.at_end   = is_right ? ({1'b0, r_cur} == loci_last) : (r_cur == '0);
        o_stat.out_free = !r_out_valid || i_out_ready;
        o_stat.near_sel = r_near_sel;
    end

    // table: one write port for loads, one registered read port for walks
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_table[i_in_word.index] <= i_in_word.position;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_idx) begin
            r_idx <= i_in_word.index;
        end
        if (i_cmd.cur_load) begin
            r_cur <= r_idx;
        end else if (i_cmd.cur_step) begin
            r_cur <= cur_next;
        end
        if (i_cmd.cap_ref) begin
            r_ref <= r_rd_data;
        end
        if (i_cmd.cap_outer) begin
            r_outer <= r_rd_data;
        end
        if (i_cmd.bnd_we) begin
            if (is_right) begin
                r_stop <= bound;
            end else begin
                r_start <= bound;
            end
        end
        if (i_cmd.out_load) begin
            r_out_word.window_found  <= win_ok;
            r_out_word.left_count    <= win_ok ? (r_idx - r_start) : '0;
            r_out_word.right_count   <= win_ok ? (r_stop - r_idx) : '0;
            r_out_word.window_length <= win_ok ? win_len : '0;
            r_out_word.max_length    <= longest_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= '0;
            r_num_loci    <= '0;
            r_near_sel    <= 1'b0;
            r_longest     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[POS_W-1:0];
                    CFG_NUM_LOCI:    r_num_loci    <= i_cfg_data[LEN_W-1:0];
                    CFG_NEAR_SEL:    r_near_sel    <= i_cfg_data[0];
                    default:         r_near_sel    <= r_near_sel;
                endcase
            end
            if (i_cmd.clr_longest) begin
                r_longest <= '0;
            end else if (i_cmd.out_load) begin
                r_longest <= longest_upd;
            end
            // hold the word until taken
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

/* hw/rtl/position_window_bound_search_core.sv */
// Top level of the position window bound search: controller, datapath and checks.
//
//  channel  | dir | word        | handshake
//  ---------+-----+-------------+---------------------------------------
//  i_in     | in  | t_in_word   | valid/ready, taken when both high
//  o_out    | out | t_out_word  | valid/ready, held until taken
//  i_cfg_*  | in  | 32-bit data | write enable, index 0..2, no read-back
//
// A load is written in the cycle it is taken and gives no result. After it is taken, a
// query goes straight to its result when the centre is rejected; else it reads the
// centre, walks right, then walks left from the centre again, with one more read per
// side when the nearest bound is picked: the single table read port delivers one entry
// per cycle. Reset is synchronous, active low; the table is not cleared. A finished
// result waits in the output register while the next word is accepted; the following
// query holds in its last step until that result is taken.
`default_nettype none

module position_window_bound_search_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [pwbs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [pwbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pwbs_in_if.sink                          i_in,
    pwbs_out_if.source                       o_out
);
    import pwbs_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    pwbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.data.func),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    pwbs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in.data),
        .i_cmd       (cmd),
        .i_out_ready (o_out.ready),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .o_out_word  (o_out.data)
    );

    assign i_in.ready = in_ready;

    // a query keeps the input closed while it runs
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.data.func == FUNC_QUERY) |=> !i_in.ready)
        else $error("input left open after a query was taken");

    // a load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.data.func == FUNC_LOAD && !o_out.valid)
        |=> !o_out.valid)
        else $error("result raised after a load");

    a_len_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.window_found) |->
        (o_out.data.window_length ==
         ({1'b0, o_out.data.left_count} + {1'b0, o_out.data.right_count} + 13'd1)))
        else $error("window length does not match its counts");

    a_max_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.window_found) |->
        (o_out.data.max_length >= o_out.data.window_length))
        else $error("running maximum below the reported window");

endmodule

`default_nettype wire
